// ----- hw/rtl/dcmd_pkg.sv -----
package dcmd_pkg;

    // Default widths
    localparam int CELL_WIDTH_DEF = 32;
    localparam int BASE_WIDTH_DEF = 16;

    // Command codes
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_UMUL = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SMUL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UDIV = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FDIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SDIV = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BDIV = 3'd5;

endpackage

// ----- hw/rtl/dcmd_alu.sv -----
module dcmd_alu #(
    parameter int WIDTH = dcmd_pkg::CELL_WIDTH_DEF
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_cin,
    output logic [WIDTH-1:0] o_sum,
    output logic             o_cout
);

    // One shared adder: subtract and negate are formed by the caller
    logic [WIDTH:0] sum_full;

    assign sum_full = {1'b0, i_a} + {1'b0, i_b} + {{WIDTH{1'b0}}, i_cin};
    assign o_sum    = sum_full[WIDTH-1:0];
    assign o_cout   = sum_full[WIDTH];

endmodule

// ----- hw/rtl/double_cell_mul_div_unit.sv -----
// busy is high in every state but idle: the magnitude, multiply or divide, sign-fix and
// done states. A zero divisor or an unused command goes straight to the done state.
// o_valid is registered from the done state and rises as busy falls.
// A new command is taken only while idle, once the last one is through; the single shared
// adder takes one multiply or divide bit per cycle. The receiver cannot stall.
// Reset (synchronous, active low) idles the sequencer and drops any pending strobe.
module double_cell_mul_div_unit #(
    parameter int CELL_WIDTH = dcmd_pkg::CELL_WIDTH_DEF,
    parameter int BASE_WIDTH = dcmd_pkg::BASE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [dcmd_pkg::CMD_W-1:0] i_cmd,
    input  logic [CELL_WIDTH-1:0]      i_num_hi,
    input  logic [CELL_WIDTH-1:0]      i_num_lo,
    input  logic [CELL_WIDTH-1:0]      i_operand_b,
    output logic                       o_valid,
    output logic [CELL_WIDTH-1:0]      o_result_hi,
    output logic [CELL_WIDTH-1:0]      o_result_lo,
    output logic [CELL_WIDTH-1:0]      o_quotient,
    output logic [CELL_WIDTH-1:0]      o_remainder,
    output logic                       o_div_error
);

    localparam int W     = CELL_WIDTH;
    localparam int CNT_W = $clog2(2 * CELL_WIDTH);
    localparam int ST_W  = 4;

    // Sequencer states
    localparam logic [ST_W-1:0] S_IDLE = 4'd0;
    localparam logic [ST_W-1:0] S_PLO  = 4'd1;
    localparam logic [ST_W-1:0] S_PHI  = 4'd2;
    localparam logic [ST_W-1:0] S_PY   = 4'd3;
    localparam logic [ST_W-1:0] S_MUL  = 4'd4;
    localparam logic [ST_W-1:0] S_DIV  = 4'd5;
    localparam logic [ST_W-1:0] S_MLO  = 4'd6;
    localparam logic [ST_W-1:0] S_MHI  = 4'd7;
    localparam logic [ST_W-1:0] S_FQ   = 4'd8;
    localparam logic [ST_W-1:0] S_FR   = 4'd9;
    localparam logic [ST_W-1:0] S_FN   = 4'd10;
    localparam logic [ST_W-1:0] S_DONE = 4'd11;

    logic [ST_W-1:0]               r_state, n_state;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [dcmd_pkg::CMD_W-1:0]    r_cmd, n_cmd;
    logic [W-1:0]                  r_acc_hi, n_acc_hi;
    logic [W-1:0]                  r_acc_lo, n_acc_lo;
    logic [W-1:0]                  r_rem, n_rem;
    logic [W-1:0]                  r_y, n_y;
    logic                          r_neg_n, n_neg_n;
    logic                          r_neg_d, n_neg_d;
    logic                          r_err, n_err;
    logic                          r_carry, n_carry;
    logic                          r_valid, n_valid;
    logic [W-1:0]                  r_out_hi, n_out_hi;
    logic [W-1:0]                  r_out_lo, n_out_lo;
    logic [W-1:0]                  r_out_q, n_out_q;
    logic [W-1:0]                  r_out_r, n_out_r;
    logic                          r_out_err, n_out_err;

    logic [W-1:0] alu_a, alu_b, alu_sum;
    logic         alu_cin, alu_cout;
    logic [W-1:0] div_shift;
    logic         is_sdiv, is_fdiv, sign_diff, rem_zero, neg_flag;
    logic         accept, b_zero, base_zero;
    logic [W-1:0] base_ext;

    assign accept    = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign is_fdiv   = (r_cmd == dcmd_pkg::CMD_FDIV);
    assign is_sdiv   = is_fdiv || (r_cmd == dcmd_pkg::CMD_SDIV);
    assign sign_diff = r_neg_n ^ r_neg_d;
    assign rem_zero  = (r_rem == '0);
    assign div_shift = {r_rem[W-2:0], r_acc_hi[W-1]};
    assign b_zero    = (i_operand_b == '0);
    assign base_zero = (i_operand_b[BASE_WIDTH-1:0] == '0);
    assign base_ext  = {{(W - BASE_WIDTH){1'b0}}, i_operand_b[BASE_WIDTH-1:0]};

    dcmd_alu #(
        .WIDTH (W)
    ) u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_cin  (alu_cin),
        .o_sum  (alu_sum),
        .o_cout (alu_cout)
    );

    // Select the adder operands for the current step
    always_comb begin
        alu_a    = '0;
        alu_b    = '0;
        alu_cin  = 1'b0;
        neg_flag = 1'b0;
        unique case (r_state)
            S_PLO, S_MLO: begin
                neg_flag = (r_state == S_PLO) ? r_neg_n : sign_diff;
                alu_a    = neg_flag ? ~r_acc_lo : r_acc_lo;
                alu_cin  = neg_flag;
            end
            S_PHI, S_MHI: begin
                neg_flag = (r_state == S_PHI) ? (r_neg_n && is_sdiv) : sign_diff;
                alu_a    = neg_flag ? ~r_acc_hi : r_acc_hi;
                alu_cin  = neg_flag && r_carry;
            end
            S_PY: begin
                alu_a   = r_neg_d ? ~r_y : r_y;
                alu_cin = r_neg_d;
            end
            S_MUL: begin
                alu_a = r_acc_hi;
                alu_b = r_acc_lo[0] ? r_y : '0;
            end
            S_DIV: begin
                alu_a   = div_shift;
                alu_b   = ~r_y;
                alu_cin = 1'b1;
            end
            S_FQ: begin
                alu_a   = sign_diff ? ~r_acc_lo : r_acc_lo;
                alu_cin = sign_diff && (is_fdiv ? rem_zero : 1'b1);
            end
            S_FR: begin
                alu_a   = r_y;
                alu_b   = ~r_rem;
                alu_cin = 1'b1;
            end
            S_FN: begin
                neg_flag = is_fdiv ? r_neg_d : r_neg_n;
                alu_a    = neg_flag ? ~r_rem : r_rem;
                alu_cin  = neg_flag;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // Sequencer and datapath next values
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_cmd     = r_cmd;
        n_acc_hi  = r_acc_hi;
        n_acc_lo  = r_acc_lo;
        n_rem     = r_rem;
        n_y       = r_y;
        n_neg_n   = r_neg_n;
        n_neg_d   = r_neg_d;
        n_err     = r_err;
        n_carry   = r_carry;
        n_valid   = 1'b0;
        n_out_hi  = r_out_hi;
        n_out_lo  = r_out_lo;
        n_out_q   = r_out_q;
        n_out_r   = r_out_r;
        n_out_err = r_out_err;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_cmd;
                    n_acc_lo = i_num_lo;
                    n_rem    = '0;
                    n_err    = 1'b0;
                    n_neg_n  = 1'b0;
                    n_neg_d  = 1'b0;
                    n_acc_hi = i_num_hi;
                    n_y      = i_operand_b;
                    n_cnt    = CNT_W'(2 * W - 1);
                    unique case (i_cmd) inside
                        dcmd_pkg::CMD_UMUL: begin
                            n_acc_hi = '0;
                            n_cnt    = CNT_W'(W - 1);
                            n_state  = S_MUL;
                        end
                        dcmd_pkg::CMD_SMUL: begin
                            n_acc_hi = '0;
                            n_neg_n  = i_num_lo[W-1];
                            n_neg_d  = i_operand_b[W-1];
                            n_state  = S_PLO;
                        end
                        dcmd_pkg::CMD_UDIV: begin
                            n_err   = b_zero;
                            n_state = b_zero ? S_DONE : S_DIV;
                        end
                        dcmd_pkg::CMD_FDIV, dcmd_pkg::CMD_SDIV: begin
                            n_err   = b_zero;
                            n_neg_n = i_num_hi[W-1];
                            n_neg_d = i_operand_b[W-1];
                            n_state = b_zero ? S_DONE : S_PLO;
                        end
                        dcmd_pkg::CMD_BDIV: begin
                            n_err   = base_zero;
                            n_y     = base_ext;
                            n_state = base_zero ? S_DONE : S_DIV;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            // Take magnitudes of the signed operands
            S_PLO: begin
                n_acc_lo = alu_sum;
                n_carry  = alu_cout;
                n_state  = S_PHI;
            end
            S_PHI: begin
                n_acc_hi = alu_sum;
                n_state  = S_PY;
            end
            S_PY: begin
                n_y = alu_sum;
                if (r_cmd == dcmd_pkg::CMD_SMUL) begin
                    n_cnt   = CNT_W'(W - 1);
                    n_state = S_MUL;
                end else begin
                    n_cnt   = CNT_W'(2 * W - 1);
                    n_state = S_DIV;
                end
            end
            // Add and shift right, one multiplier bit per cycle
            S_MUL: begin
                n_acc_hi = {alu_cout, alu_sum[W-1:1]};
                n_acc_lo = {alu_sum[0], r_acc_lo[W-1:1]};
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = (r_cmd == dcmd_pkg::CMD_SMUL) ? S_MLO : S_DONE;
                end
            end
            // Restoring divide step: shift in a dividend bit, subtract if it fits
            S_DIV: begin
                if (r_rem[W-1] || alu_cout) begin
                    n_rem = alu_sum;
                end else begin
                    n_rem = div_shift;
                end
                n_acc_hi = {r_acc_hi[W-2:0], r_acc_lo[W-1]};
                n_acc_lo = {r_acc_lo[W-2:0], r_rem[W-1] || alu_cout};
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = is_sdiv ? S_FQ : S_DONE;
                end
            end
            // Apply the product sign
            S_MLO: begin
                n_acc_lo = alu_sum;
                n_carry  = alu_cout;
                n_state  = S_MHI;
            end
            S_MHI: begin
                n_acc_hi = alu_sum;
                n_state  = S_DONE;
            end
            // Fix quotient and remainder signs
            S_FQ: begin
                n_acc_lo = alu_sum;
                n_state  = S_FR;
            end
            S_FR: begin
                if (is_fdiv && sign_diff && !rem_zero) begin
                    n_rem = alu_sum;
                end
                n_state = S_FN;
            end
            S_FN: begin
                n_rem   = alu_sum;
                n_state = S_DONE;
            end
            // Present the result beat
            S_DONE: begin
                n_valid   = 1'b1;
                n_out_hi  = '0;
                n_out_lo  = '0;
                n_out_q   = '0;
                n_out_r   = '0;
                n_out_err = r_err;
                if (!r_err) begin
                    case (r_cmd) inside
                        dcmd_pkg::CMD_UMUL, dcmd_pkg::CMD_SMUL: begin
                            n_out_hi = r_acc_hi;
                            n_out_lo = r_acc_lo;
                        end
                        dcmd_pkg::CMD_UDIV, dcmd_pkg::CMD_FDIV, dcmd_pkg::CMD_SDIV: begin
                            n_out_q = r_acc_lo;
                            n_out_r = r_rem;
                        end
                        dcmd_pkg::CMD_BDIV: begin
                            n_out_hi = r_acc_hi;
                            n_out_lo = r_acc_lo;
                            n_out_r  = r_rem;
                        end
                        default: begin
                            n_out_err = 1'b0;
                        end
                    endcase
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Datapath and result registers
    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_cmd     <= n_cmd;
        r_acc_hi  <= n_acc_hi;
        r_acc_lo  <= n_acc_lo;
        r_rem     <= n_rem;
        r_y       <= n_y;
        r_neg_n   <= n_neg_n;
        r_neg_d   <= n_neg_d;
        r_err     <= n_err;
        r_carry   <= n_carry;
        r_out_hi  <= n_out_hi;
        r_out_lo  <= n_out_lo;
        r_out_q   <= n_out_q;
        r_out_r   <= n_out_r;
        r_out_err <= n_out_err;
    end

    assign o_valid     = r_valid;
    assign o_result_hi = r_out_hi;
    assign o_result_lo = r_out_lo;
    assign o_quotient  = r_out_q;
    assign o_remainder = r_out_r;
    assign o_div_error = r_out_err;

endmodule

// ----- tb/sv/double_cell_mul_div_unit_tb.sv -----
module double_cell_mul_div_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = dcmd_pkg::CELL_WIDTH_DEF;
    localparam int BW = dcmd_pkg::BASE_WIDTH_DEF;
    localparam int RANDOM_BEATS = 1700;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 2 * CW + 16;

    // Codes the block decodes to an all-zero result
    localparam logic [dcmd_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [dcmd_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef logic [dcmd_pkg::CMD_W-1:0] t_cmd;
    typedef logic [CW-1:0] t_cell;
    typedef logic [2*CW-1:0] t_dcell;

    typedef struct packed {
        t_cell hi;
        t_cell lo;
        t_cell quo;
        t_cell rem;
        logic  err;
    } t_mdu_result;

    // Model of the arithmetic, one command in, one result out
    function automatic t_mdu_result compute_result(t_cmd cmd, t_cell n_hi, t_cell n_lo,
                                                   t_cell b);
        t_mdu_result r;
        t_dcell num;
        t_dcell mag_n;
        t_dcell q;
        t_dcell prod;
        t_cell mag_a;
        t_cell mag_b;
        t_cell mag_d;
        t_cell quo;
        t_cell rem;
        logic neg_n;
        logic neg_d;
        logic [BW-1:0] base;
        r = '0;
        num = {n_hi, n_lo};
        case (cmd)
            dcmd_pkg::CMD_UMUL: begin
                prod = t_dcell'(n_lo) * t_dcell'(b);
                {r.hi, r.lo} = prod;
            end
            dcmd_pkg::CMD_SMUL: begin
                mag_a = n_lo[CW-1] ? t_cell'(-n_lo) : n_lo;
                mag_b = b[CW-1] ? t_cell'(-b) : b;
                prod = t_dcell'(mag_a) * t_dcell'(mag_b);
                if (n_lo[CW-1] ^ b[CW-1])
                    prod = -prod;
                {r.hi, r.lo} = prod;
            end
            dcmd_pkg::CMD_UDIV, dcmd_pkg::CMD_FDIV, dcmd_pkg::CMD_SDIV: begin
                if (b == '0) begin
                    r.err = 1'b1;
                end else if (cmd == dcmd_pkg::CMD_UDIV) begin
                    q = num / t_dcell'(b);
                    r.quo = q[CW-1:0];
                    r.rem = t_cell'(num % t_dcell'(b));
                end else begin
                    neg_n = n_hi[CW-1];
                    neg_d = b[CW-1];
                    mag_d = neg_d ? t_cell'(-b) : b;
                    mag_n = neg_n ? t_dcell'(-num) : num;
                    q = mag_n / t_dcell'(mag_d);
                    quo = q[CW-1:0];
                    rem = t_cell'(mag_n % t_dcell'(mag_d));
                    if (cmd == dcmd_pkg::CMD_FDIV) begin
                        // round toward minus infinity, remainder follows divisor
                        if (neg_n != neg_d) begin
                            quo = -quo;
                            if (rem != '0) begin
                                quo = quo - 1'b1;
                                rem = mag_d - rem;
                            end
                        end
                        if (neg_d)
                            rem = -rem;
                    end else begin
                        // truncate toward zero, remainder follows dividend
                        if (neg_n)
                            rem = -rem;
                        if (neg_n != neg_d)
                            quo = -quo;
                    end
                    r.quo = quo;
                    r.rem = rem;
                end
            end
            dcmd_pkg::CMD_BDIV: begin
                base = b[BW-1:0];
                if (base == '0) begin
                    r.err = 1'b1;
                end else begin
                    q = num / t_dcell'(base);
                    {r.hi, r.lo} = q;
                    r.rem = t_cell'(num % t_dcell'(base));
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    class mul_div_scoreboard;
        t_mdu_result pending_results[$];
        int mismatches;

        function void note_command(t_cmd cmd, t_cell n_hi, t_cell n_lo, t_cell b);
            pending_results.push_back(compute_result(cmd, n_hi, n_lo, b));
        endfunction

        function void check_result(t_mdu_result got);
            t_mdu_result want;
            if (pending_results.size() == 0) begin
                $error("result beat with no command outstanding");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (got.hi !== want.hi) begin
                $error("result_hi: expected %h, got %h", want.hi, got.hi);
                mismatches++;
            end
            if (got.lo !== want.lo) begin
                $error("result_lo: expected %h, got %h", want.lo, got.lo);
                mismatches++;
            end
            if (got.quo !== want.quo) begin
                $error("quotient: expected %h, got %h", want.quo, got.quo);
                mismatches++;
            end
            if (got.rem !== want.rem) begin
                $error("remainder: expected %h, got %h", want.rem, got.rem);
                mismatches++;
            end
            if (got.err !== want.err) begin
                $error("div_error: expected %b, got %b", want.err, got.err);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_cmd i_cmd;
    t_cell i_num_hi;
    t_cell i_num_lo;
    t_cell i_operand_b;
    logic o_valid;
    t_cell o_result_hi;
    t_cell o_result_lo;
    t_cell o_quotient;
    t_cell o_remainder;
    logic o_div_error;

    mul_div_scoreboard sb;
    int quiet_cycles;

    double_cell_mul_div_unit #(
        .CELL_WIDTH(CW),
        .BASE_WIDTH(BW)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_num_hi   (i_num_hi),
        .i_num_lo   (i_num_lo),
        .i_operand_b(i_operand_b),
        .o_valid    (o_valid),
        .o_result_hi(o_result_hi),
        .o_result_lo(o_result_lo),
        .o_quotient (o_quotient),
        .o_remainder(o_remainder),
        .o_div_error(o_div_error)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    // Sample both handshakes at the rising edge; check before noting a new command
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                sb.check_result('{o_result_hi, o_result_lo, o_quotient, o_remainder,
                                  o_div_error});
            end
            if (start && busy === 1'b0) begin
                sb.note_command(i_cmd, i_num_hi, i_num_lo, i_operand_b);
            end
            if ((o_valid === 1'b1) || (start && busy === 1'b0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic t_cell pick_cell();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return {1'b1, {(CW-1){1'b0}}};
            3: return {1'b0, {(CW-1){1'b1}}};
            4: return t_cell'($urandom_range(0, 15));
            5: return -t_cell'($urandom_range(1, 16));
            6: return t_cell'(1) << $urandom_range(0, CW - 1);
            default: return t_cell'({$urandom, $urandom});
        endcase
    endfunction

    // Hold a command beat until the block takes it; caller resumes at a falling edge
    task automatic send_command(t_cmd cmd, t_cell n_hi, t_cell n_lo, t_cell b);
        logic taken;
        start = 1'b1;
        i_cmd = cmd;
        i_num_hi = n_hi;
        i_num_lo = n_lo;
        i_operand_b = b;
        do begin
            @(posedge i_clk);
            taken = (busy === 1'b0);
            @(negedge i_clk);
        end while (!taken);
    endtask

    // Drop start for a burst, with junk on the data ports
    task automatic idle_burst(int cycles);
        start = 1'b0;
        repeat (cycles) begin
            i_cmd = t_cmd'($urandom);
            i_num_hi = pick_cell();
            i_num_lo = pick_cell();
            i_operand_b = pick_cell();
            @(negedge i_clk);
        end
    endtask

    task automatic send_random_command();
        t_cmd cmd;
        t_cell n_hi;
        t_cell n_lo;
        t_cell b;
        if ($urandom_range(0, 99) < 94)
            cmd = t_cmd'($urandom_range(0, 5));
        else
            cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
        n_hi = pick_cell();
        n_lo = pick_cell();
        b = pick_cell();
        // keep most divisors nonzero, and most unsigned quotients in range
        if (b == '0 && $urandom_range(0, 3) != 0)
            b = t_cell'({$urandom, $urandom}) | t_cell'(1);
        if (cmd == dcmd_pkg::CMD_BDIV && b[BW-1:0] == '0 && $urandom_range(0, 3) != 0)
            b[0] = 1'b1;
        if (cmd == dcmd_pkg::CMD_UDIV && b != '0 && $urandom_range(0, 1) != 0)
            n_hi = n_hi % b;
        send_command(cmd, n_hi, n_lo, b);
    endtask

    initial begin
        int gap_pct;
        sb = new();
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_num_hi = '0;
        i_num_lo = '0;
        i_operand_b = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corners: extremes, sign mixes, zero divisors, wrap, spare codes
        send_command(dcmd_pkg::CMD_UMUL, '0, '1, '1);
        send_command(dcmd_pkg::CMD_UMUL, '1, '0, '1);
        send_command(dcmd_pkg::CMD_SMUL, '0, {1'b1, {(CW-1){1'b0}}},
                     {1'b1, {(CW-1){1'b0}}});
        send_command(dcmd_pkg::CMD_SMUL, '0, {1'b1, {(CW-1){1'b0}}}, '1);
        send_command(dcmd_pkg::CMD_SMUL, '1, '1, {1'b0, {(CW-1){1'b1}}});
        send_command(dcmd_pkg::CMD_UDIV, '1, '1, '0);
        send_command(dcmd_pkg::CMD_UDIV, '1, '1, t_cell'(1));
        send_command(dcmd_pkg::CMD_UDIV, t_cell'(5), '1, '1);
        send_command(dcmd_pkg::CMD_FDIV, '1, -t_cell'(7), t_cell'(2));
        send_command(dcmd_pkg::CMD_FDIV, '0, t_cell'(7), -t_cell'(2));
        send_command(dcmd_pkg::CMD_FDIV, '1, -t_cell'(7), -t_cell'(2));
        send_command(dcmd_pkg::CMD_FDIV, '1, -t_cell'(6), t_cell'(3));
        send_command(dcmd_pkg::CMD_FDIV, {1'b1, {(CW-1){1'b0}}}, '0, '1);
        send_command(dcmd_pkg::CMD_FDIV, t_cell'(3), t_cell'(9), '0);
        send_command(dcmd_pkg::CMD_SDIV, '1, -t_cell'(7), t_cell'(2));
        send_command(dcmd_pkg::CMD_SDIV, '0, t_cell'(7), -t_cell'(2));
        send_command(dcmd_pkg::CMD_SDIV, {1'b1, {(CW-1){1'b0}}}, '0,
                     {1'b1, {(CW-1){1'b0}}});
        send_command(dcmd_pkg::CMD_SDIV, '1, '1, '0);
        send_command(dcmd_pkg::CMD_BDIV, '1, '1, t_cell'(10));
        send_command(dcmd_pkg::CMD_BDIV, '1, '1, t_cell'(1) << BW);
        send_command(dcmd_pkg::CMD_BDIV, '1, '1, '1);
        send_command(dcmd_pkg::CMD_BDIV, '0, t_cell'(12345), t_cell'(1));
        send_command(CMD_SPARE6, '1, '1, '1);
        send_command(CMD_SPARE7, '1, '1, '1);

        // Random beats: idle phases alternate, the tail runs back to back
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            case ((n / 100) % 3)
                0: gap_pct = 30;
                1: gap_pct = 0;
                default: gap_pct = 60;
            endcase
            if (n >= RANDOM_BEATS - 200)
                gap_pct = 0;
            send_random_command();
            if ($urandom_range(0, 99) < gap_pct)
                idle_burst($urandom_range(1, 15));
        end
        start = 1'b0;

        // Drain, then allow the block's own latency for any stray beat
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
